### src/esfd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// esfd_pkg
// Shared types and constants of the escape-stuffed frame decoder: line
// control bytes, receiver states, result kinds and frame status codes.
// ----------------------------------------------------------------------------
package esfd_pkg;

  localparam logic [7:0] EscByte   = 8'h5A;
  localparam logic [7:0] StartByte = 8'h02;
  localparam logic [7:0] EndByte   = 8'h03;

  typedef enum logic [1:0] {
    ST_HUNT = 2'd0,
    ST_OPEN = 2'd1,
    ST_DATA = 2'd2,
    ST_ESC  = 2'd3
  } rx_state_e;

  typedef enum logic [1:0] {
    KIND_DATA  = 2'd0,
    KIND_END   = 2'd1,
    KIND_ABORT = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_CHECKSUM  = 2'd1,
    STAT_TOO_SHORT = 2'd2,
    STAT_OVERFLOW  = 2'd3
  } status_e;

endpackage
`default_nettype wire

### src/escape_stuffed_frame_decoder.sv
`default_nettype none
// ----------------------------------------------------------------------------
// escape_stuffed_frame_decoder
// Byte-stuffed frame receiver with XOR checksum. Unstuffs the line stream,
// gives out frame bytes one byte late with their index, and reports length
// and status when a frame closes or an abort when it breaks.
// ----------------------------------------------------------------------------
//   Channel  Dir  Handshake               Payload
//   in       in   in_valid_i/in_ready_o   rx_byte_i
//   out      out  out_valid_o/out_ready_i kind_o, data_byte_o, byte_index_o,
//                                         status_o, payload_length_o
//
// Each input item is decoded in the cycle it is accepted and its result, if
// any, appears in the output register on the next cycle: one item per cycle.
// The input is ready whenever the output register is empty or being taken,
// so a held result stalls the input only while out_ready_i is low.
// Reset clears the receiver to hunting for a frame start; no clearing pass.
// ----------------------------------------------------------------------------
module escape_stuffed_frame_decoder
  import esfd_pkg::*;
#(
  parameter int MAX_FRAME    = 256,
  parameter int HEADER_BYTES = 7
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic [7:0] rx_byte_i,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output logic [1:0]      kind_o,
  output logic [7:0]      data_byte_o,
  output logic [7:0]      byte_index_o,
  output logic [1:0]      status_o,
  output logic [7:0]      payload_length_o
);

  localparam int CntW = $clog2(MAX_FRAME + 1);
  localparam int ExtW = (CntW > 8) ? CntW : 8;

  rx_state_e        rx_state_q, rx_state_d;
  logic [CntW-1:0]  count_q, count_d;
  logic [7:0]       xor_q, xor_d;
  logic [7:0]       held_q, held_d;
  logic             held_valid_q, held_valid_d;
  logic             ovf_q, ovf_d;

  logic             out_valid_q, out_valid_d;
  kind_e            kind_q, kind_d;
  logic [7:0]       data_q, data_d;
  logic [7:0]       index_q, index_d;
  status_e          status_q, status_d;
  logic [7:0]       length_q, length_d;

  logic             in_fire;
  logic             emit;
  logic [ExtW-1:0]  count_ext;
  logic [ExtW-1:0]  index_ext;
  logic [ExtW-1:0]  len_ext;
  logic             short_frame;
  logic             full_frame;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_fire    = in_valid_i && in_ready_o;

  assign count_ext   = ExtW'(count_q);
  assign index_ext   = count_ext - ExtW'(1);
  assign short_frame = count_ext < ExtW'(HEADER_BYTES + 1);
  assign len_ext     = count_ext - ExtW'(HEADER_BYTES + 1);
  assign full_frame  = count_q >= CntW'(MAX_FRAME);

  always_comb begin
    rx_state_d = rx_state_q;
    unique case (rx_state_q)
      ST_HUNT: begin
        if (rx_byte_i == EscByte) rx_state_d = ST_OPEN;
      end
      ST_OPEN: begin
        rx_state_d = (rx_byte_i == StartByte) ? ST_DATA : ST_HUNT;
      end
      ST_DATA: begin
        if (rx_byte_i == EscByte) rx_state_d = ST_ESC;
      end
      ST_ESC: begin
        if (rx_byte_i == EscByte || rx_byte_i == StartByte) begin
          rx_state_d = ST_DATA;
        end else begin
          rx_state_d = ST_HUNT;
        end
      end
      default: rx_state_d = ST_HUNT;
    endcase
  end

  always_comb begin
    logic take_byte;
    logic clear;
    take_byte    = 1'b0;
    clear        = 1'b0;
    emit         = 1'b0;
    count_d      = count_q;
    xor_d        = xor_q;
    held_d       = held_q;
    held_valid_d = held_valid_q;
    ovf_d        = ovf_q;
    kind_d       = kind_q;
    data_d       = data_q;
    index_d      = index_q;
    status_d     = status_q;
    length_d     = length_q;

    unique case (rx_state_q)
      ST_HUNT: ;
      ST_OPEN: begin
        if (rx_byte_i == StartByte) clear = 1'b1;
      end
      ST_DATA: begin
        if (rx_byte_i != EscByte) take_byte = 1'b1;
      end
      ST_ESC: begin
        if (rx_byte_i == EscByte) begin
          take_byte = 1'b1;
        end else if (rx_byte_i == EndByte) begin
          emit     = 1'b1;
          clear    = 1'b1;
          kind_d   = KIND_END;
          data_d   = '0;
          index_d  = '0;
          length_d = '0;
          if (!short_frame) begin
            length_d = (len_ext > ExtW'(255)) ? 8'd255 : len_ext[7:0];
          end
          if (ovf_q) begin
            status_d = STAT_OVERFLOW;
          end else if (short_frame) begin
            status_d = STAT_TOO_SHORT;
          end else if (xor_q != held_q) begin
            status_d = STAT_CHECKSUM;
          end else begin
            status_d = STAT_OK;
          end
        end else begin
          emit     = 1'b1;
          clear    = 1'b1;
          kind_d   = KIND_ABORT;
          data_d   = '0;
          index_d  = '0;
          status_d = STAT_OK;
          length_d = '0;
        end
      end
      default: ;
    endcase

    if (take_byte) begin
      if (full_frame) begin
        ovf_d = 1'b1;
      end else begin
        if (held_valid_q) begin
          emit     = 1'b1;
          kind_d   = KIND_DATA;
          data_d   = held_q;
          index_d  = index_ext[7:0];
          status_d = STAT_OK;
          length_d = '0;
          xor_d    = xor_q ^ held_q;
        end
        held_d       = rx_byte_i;
        held_valid_d = 1'b1;
        count_d      = count_q + CntW'(1);
      end
    end

    if (clear) begin
      count_d      = '0;
      xor_d        = '0;
      held_d       = '0;
      held_valid_d = 1'b0;
      ovf_d        = 1'b0;
    end

    if (in_fire && emit) begin
      out_valid_d = 1'b1;
    end else begin
      out_valid_d = out_valid_q && !out_ready_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rx_state_q   <= ST_HUNT;
      count_q      <= '0;
      xor_q        <= '0;
      held_q       <= '0;
      held_valid_q <= 1'b0;
      ovf_q        <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (in_fire) begin
        rx_state_q   <= rx_state_d;
        count_q      <= count_d;
        xor_q        <= xor_d;
        held_q       <= held_d;
        held_valid_q <= held_valid_d;
        ovf_q        <= ovf_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire && emit) begin
      kind_q   <= kind_d;
      data_q   <= data_d;
      index_q  <= index_d;
      status_q <= status_d;
      length_q <= length_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign kind_o           = kind_q;
  assign data_byte_o      = data_q;
  assign byte_index_o     = index_q;
  assign status_o         = status_q;
  assign payload_length_o = length_q;

  a_held_has_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    held_valid_q |-> (count_q != '0))
    else $error("held byte present with an empty frame count");

  a_count_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(MAX_FRAME))
    else $error("frame count beyond maximum frame size");

  a_short_no_length: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && kind_o == KIND_END && status_o == STAT_TOO_SHORT)
      |-> (payload_length_o == 8'd0))
    else $error("too-short frame reported with a payload length");

  a_no_result_while_hunting: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && (rx_state_q == ST_HUNT || rx_state_q == ST_OPEN) && !out_valid_q)
      |=> !out_valid_o)
    else $error("result produced for a byte outside a frame");

endmodule
`default_nettype wire
